>>> src/cia_pkg.sv
`default_nettype none
package cia_pkg;
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_KEY   = 2'd3;

   localparam logic [3:0] REG_PRA   = 4'd0;
   localparam logic [3:0] REG_PRB   = 4'd1;
   localparam logic [3:0] REG_DDRA  = 4'd2;
   localparam logic [3:0] REG_DDRB  = 4'd3;
   localparam logic [3:0] REG_TALO  = 4'd4;
   localparam logic [3:0] REG_TAHI  = 4'd5;
   localparam logic [3:0] REG_TBLO  = 4'd6;
   localparam logic [3:0] REG_TBHI  = 4'd7;
   localparam logic [3:0] REG_TOD10 = 4'd8;
   localparam logic [3:0] REG_TODS  = 4'd9;
   localparam logic [3:0] REG_TODM  = 4'd10;
   localparam logic [3:0] REG_TODH  = 4'd11;
   localparam logic [3:0] REG_SDR   = 4'd12;
   localparam logic [3:0] REG_ICR   = 4'd13;
   localparam logic [3:0] REG_CRA   = 4'd14;
   localparam logic [3:0] REG_CRB   = 4'd15;

   localparam logic [15:0] TA_RESET = 16'h4025;
   localparam logic [15:0] TB_RESET = 16'hFFFF;

   localparam int REQ_WIDTH = 40;
   localparam int RSP_WIDTH = 32;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  reg_index;
      logic [7:0]  write_data;
      logic [15:0] elapsed_cycles;
      logic [2:0]  key_col;
      logic [2:0]  key_row;
      logic        key_down;
   } req_type;

   // Packed with read_data in the lowest bits.
   typedef struct packed {
      logic [15:0] video_bank_base;
      logic        nmi_pulse;
      logic        irq_pulse;
      logic [7:0]  read_data;
   } rsp_type;
endpackage
`default_nettype wire

>>> src/complex_interface_adapter_core.sv
// A response is registered in the output register, or in the skid stage on a stall.
// Throughput: one request per cycle unless the skid stage is full; the output
// register and the skid stage let a new request enter while a response still waits.
// Reset: synchronous, active high; all peripheral registers take their documented
// values, with the key matrix all ones and the time of day running.
`default_nettype none
module complex_interface_adapter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // op
   input  wire logic [1:0]  req_tuser,
   // reg_index, write_data, elapsed_cycles, key_col, key_row, key_down
   input  wire logic [cia_pkg::REQ_WIDTH-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data, irq_pulse, nmi_pulse, video_bank_base (bits 25:0)
   output logic [cia_pkg::RSP_WIDTH-1:0] rsp_tdata
);
   import cia_pkg::*;

   logic second_ff;
   logic [7:0] pa_ff, pb_ff, da_ff, db_ff, cra_ff, crb_ff, sdr_ff;
   logic [15:0] la_ff, ca_ff, lb_ff, cb_ff, lca_ff, bank_ff;
   logic [3:0] mask_ff;
   logic [4:0] flags_ff;
   logic [31:0] tod_ff, snap_ff;
   logic run_ff, latched_ff;
   logic [7:0] km_ff [8];

   logic [7:0] pa_in, pb_in, da_in, db_in, cra_in, crb_in, sdr_in;
   logic [15:0] la_in, ca_in, lb_in, cb_in, lca_in, bank_in;
   logic [3:0] mask_in;
   logic [4:0] flags_in;
   logic [31:0] tod_in, snap_in;
   logic run_in, latched_in;
   logic [7:0] km_in [8];

   // Output register plus skid register.
   logic out_v_ff, skid_v_ff;
   rsp_type out_ff, skid_ff;
   rsp_type res;

   req_type rq;
   logic acc;
   assign rq = '{op: req_tuser, reg_index: req_tdata[3:0], write_data: req_tdata[11:4],
                 elapsed_cycles: req_tdata[27:12], key_col: req_tdata[30:28],
                 key_row: req_tdata[33:31], key_down: req_tdata[34]};
   assign req_tready = !skid_v_ff;
   assign acc = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {6'd0, out_ff};

   logic [15:0] ta_next, tb_next;
   logic ta_uf, tb_uf;
   cia_timer u_ta (.count(ca_ff), .latch(la_ff), .control(cra_ff), .elapsed(rq.elapsed_cycles),
                   .count_next(ta_next), .underflow(ta_uf));
   cia_timer u_tb (.count(cb_ff), .latch(lb_ff), .control(crb_ff), .elapsed(rq.elapsed_cycles),
                   .count_next(tb_next), .underflow(tb_uf));

   logic [7:0] key_val, inv_pa, rd, wd, hv, t8, s8;
   logic [2:0] row;
   logic [3:0] sel;
   logic fired, fa, fb;
   always_comb begin
      inv_pa = ~pa_ff;
      row = 3'd0;
      for (int i = 1; i < 8; i++) if (inv_pa[i]) row = 3'(i);
      key_val = (pa_ff == 8'hFF || pa_ff == 8'h00) ? 8'hFF : km_ff[row];
   end

   always_comb begin
      pa_in = pa_ff; pb_in = pb_ff; da_in = da_ff; db_in = db_ff;
      cra_in = cra_ff; crb_in = crb_ff; sdr_in = sdr_ff;
      la_in = la_ff; ca_in = ca_ff; lb_in = lb_ff; cb_in = cb_ff; lca_in = lca_ff;
      bank_in = bank_ff; mask_in = mask_ff; flags_in = flags_ff;
      tod_in = tod_ff; snap_in = snap_ff; run_in = run_ff; latched_in = latched_ff;
      km_in = km_ff;
      rd = 8'd0; fired = 1'b0; fa = 1'b0; fb = 1'b0;
      wd = rq.write_data; hv = 8'd0; t8 = 8'd0; s8 = 8'd0;
      sel = {wd[4], wd[2:0]};
      unique case (rq.op)
         OP_READ: begin
            unique case (rq.reg_index)
               REG_PRA:  rd = second_ff ? (pa_ff | ~(da_ff & 8'h3F)) : key_val;
               REG_PRB:  rd = second_ff ? (pb_ff | ~(db_ff & 8'h3F)) : key_val;
               REG_DDRA: rd = da_ff;
               REG_DDRB: rd = db_ff;
               REG_TALO: rd = ca_ff[7:0];
               REG_TAHI: rd = ca_ff[15:8];
               REG_TBLO: rd = cb_ff[7:0];
               REG_TBHI: rd = cb_ff[15:8];
               REG_TOD10: begin
                  rd = latched_ff ? snap_ff[7:0] : tod_ff[7:0];
                  latched_in = 1'b0;
               end
               REG_TODS: rd = latched_ff ? snap_ff[15:8] : tod_ff[15:8];
               REG_TODM: rd = latched_ff ? snap_ff[23:16] : tod_ff[23:16];
               REG_TODH: begin
                  latched_in = 1'b1;
                  snap_in = tod_ff;
                  rd = tod_ff[31:24];
               end
               REG_SDR: rd = sdr_ff;
               REG_ICR: begin
                  rd = {flags_ff[4], 2'b00, flags_ff[3], 1'b0, flags_ff[2:0]};
                  flags_in = 5'd0;
               end
               REG_CRA: rd = cra_ff & 8'hEF;
               REG_CRB: rd = crb_ff & 8'hEF;
            endcase
         end
         OP_WRITE: begin
            unique case (rq.reg_index)
               REG_PRA: begin
                  pa_in = wd;
                  if (second_ff) bank_in = {~wd[1:0], 14'd0};
               end
               REG_PRB:  pb_in = wd;
               REG_DDRA: da_in = wd;
               REG_DDRB: db_in = wd;
               REG_TALO: la_in = {la_ff[15:8], wd};
               REG_TAHI: begin
                  la_in = {wd, la_ff[7:0]};
                  if (!cra_ff[0]) ca_in = {wd, la_ff[7:0]};
               end
               REG_TBLO: lb_in = {lb_ff[15:8], wd};
               REG_TBHI: begin
                  lb_in = {wd, lb_ff[7:0]};
                  if (!crb_ff[0]) cb_in = {wd, lb_ff[7:0]};
               end
               REG_TOD10: begin
                  tod_in[7:0] = {4'd0, wd[3:0]};
                  run_in = 1'b1;
               end
               REG_TODS: tod_in[15:8] = {1'b0, wd[6:0]};
               REG_TODM: tod_in[23:16] = {1'b0, wd[6:0]};
               REG_TODH: begin
                  hv = wd & 8'h9F;
                  // In 60 Hz mode an hour of twelve has its AM/PM bit flipped.
                  if (hv[4:0] == 5'h12 && !cra_ff[7]) hv[7] = ~hv[7];
                  tod_in[31:24] = hv;
                  run_in = 1'b0;
               end
               REG_SDR: sdr_in = wd;
               REG_ICR: mask_in = wd[7] ? (mask_ff | sel) : (mask_ff & ~sel);
               REG_CRA: cra_in = wd | (cra_ff & 8'h10);
               REG_CRB: crb_in = wd | (crb_ff & 8'h10);
            endcase
         end
         OP_TICK: begin
            ca_in = ta_next;
            cra_in[4] = 1'b0;
            if (ta_uf && mask_ff[0]) begin
               fa = 1'b1;
               flags_in = flags_in | 5'h11;
            end
            if (ta_uf && cra_ff[3]) cra_in[0] = 1'b0;
            crb_in[4] = 1'b0;
            if (crb_ff[6]) begin
               cb_in = crb_ff[4] ? lb_ff : cb_ff;
               if (crb_ff[0]) begin
                  // Chained mode: timer B follows timer A and fires on its reload.
                  cb_in = ta_next;
                  lca_in = ta_next;
                  if (ta_next > lca_ff) begin
                     if (mask_ff[1]) begin
                        fb = 1'b1;
                        flags_in = flags_in | 5'h12;
                     end
                     if (crb_ff[3]) crb_in[0] = 1'b0;
                  end
               end
            end else begin
               cb_in = tb_next;
               if (tb_uf && mask_ff[1]) begin
                  fb = 1'b1;
                  flags_in = flags_in | 5'h12;
               end
               if (tb_uf && crb_ff[3]) crb_in[0] = 1'b0;
            end
            fired = fa | fb;
            if (run_ff) begin
               t8 = {4'd0, tod_ff[3:0] + 4'd1};
               s8 = tod_ff[15:8];
               if (t8 == 8'h0A) begin
                  t8 = 8'd0;
                  s8 = (s8 + 8'd1) & 8'h7F;
                  if (s8[3:0] == 4'hA) begin
                     s8 = (s8 + 8'd6) & 8'h7F;
                     if (s8 == 8'h60) s8 = 8'd0;
                  end
               end
               tod_in[15:0] = {s8, t8};
            end
         end
         OP_KEY: begin
            if (rq.key_down) begin
               pa_in[rq.key_col] = 1'b0;
               pb_in[rq.key_row] = 1'b0;
               km_in[rq.key_col][rq.key_row] = 1'b0;
            end else begin
               pa_in[rq.key_col] = 1'b1;
               pb_in[rq.key_row] = 1'b1;
               km_in[rq.key_col][rq.key_row] = 1'b1;
            end
         end
      endcase
      res = '{video_bank_base: bank_in, nmi_pulse: fired & second_ff,
              irq_pulse: fired & ~second_ff, read_data: rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
         pa_ff <= 8'hFF; pb_ff <= 8'hFF; da_ff <= 8'hFF; db_ff <= 8'hFF;
         la_ff <= TA_RESET; ca_ff <= TA_RESET; lb_ff <= TB_RESET; cb_ff <= TB_RESET;
         lca_ff <= 16'd0; cra_ff <= 8'h81; crb_ff <= 8'h00;
         mask_ff <= 4'h1; flags_ff <= 5'd0; tod_ff <= 32'd0; snap_ff <= 32'd0;
         run_ff <= 1'b1; latched_ff <= 1'b0; sdr_ff <= 8'd0; bank_ff <= 16'd0;
         for (int i = 0; i < 8; i++) km_ff[i] <= 8'hFF;
         out_v_ff <= 1'b0; skid_v_ff <= 1'b0;
      end else begin
         if (csr_valid) second_ff <= csr_data;
         if (acc) begin
            pa_ff <= pa_in; pb_ff <= pb_in; da_ff <= da_in; db_ff <= db_in;
            la_ff <= la_in; ca_ff <= ca_in; lb_ff <= lb_in; cb_ff <= cb_in;
            lca_ff <= lca_in; cra_ff <= cra_in; crb_ff <= crb_in;
            mask_ff <= mask_in; flags_ff <= flags_in; tod_ff <= tod_in; snap_ff <= snap_in;
            run_ff <= run_in; latched_ff <= latched_in; sdr_ff <= sdr_in; bank_ff <= bank_in;
            km_ff <= km_in;
         end
         if (!out_v_ff || rsp_tready) begin
            if (skid_v_ff) begin
               out_v_ff <= 1'b1; out_ff <= skid_ff; skid_v_ff <= 1'b0;
            end else begin
               out_v_ff <= acc;
               if (acc) out_ff <= res;
            end
         end else if (acc) begin
            skid_v_ff <= 1'b1; skid_ff <= res;
         end
      end
   end
endmodule
`default_nettype wire

>>> src/cia_timer.sv
`default_nettype none
module cia_timer (
   input  wire logic [15:0] count,
   input  wire logic [15:0] latch,
   input  wire logic [7:0]  control,
   input  wire logic [15:0] elapsed,
   output logic      [15:0] count_next,
   output logic             underflow
);
   logic [15:0] start;
   always_comb begin
      start = control[4] ? latch : count;
      count_next = start;
      underflow = 1'b0;
      if (control[0]) begin
         if (elapsed > start) begin
            count_next = latch;
            underflow = 1'b1;
         end else begin
            count_next = start - elapsed;
         end
      end
   end
endmodule
`default_nettype wire

>>> src/cia_checker.sv
`default_nettype none
module cia_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);
   a_no_both_pulses: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[9] && rsp_tdata[8])) else $error("irq and nmi together");
   a_bank_low_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:10] == 14'd0) else $error("bank base low bits set");
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid) else $error("no response after request");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");
endmodule

bind complex_interface_adapter_core cia_checker u_cia_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none
module tb_top;
   import cia_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CR_RUN     = 8'h01;
   localparam logic [7:0] CR_ONESHOT = 8'h08;
   localparam logic [7:0] CR_FORCE   = 8'h10;
   localparam logic [7:0] CRA_50HZ   = 8'h80;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [1:0]  op;
      logic [3:0]  reg_index;
      logic [7:0]  write_data;
      logic [15:0] elapsed_cycles;
      logic [2:0]  key_col;
      logic [2:0]  key_row;
      logic        key_down;
   } bus_item_type;

   typedef struct {
      logic [7:0]  read_data;
      logic        irq_pulse;
      logic        nmi_pulse;
      logic [15:0] video_bank_base;
   } bus_reply_type;

   logic clock, reset;
   logic csr_valid, csr_ready, csr_data;
   logic req_tvalid, req_tready;
   logic [1:0] req_tuser;
   logic [39:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [31:0] rsp_tdata;

   complex_interface_adapter_core i_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // Shadow copy of the peripheral state.
   logic        second_unit;
   logic [7:0]  sh_port_a, sh_port_b, sh_dir_a, sh_dir_b;
   logic [15:0] sh_latch_a, sh_count_a, sh_latch_b, sh_count_b, sh_prev_count_a;
   logic [7:0]  sh_cra, sh_crb;
   logic [3:0]  sh_mask;
   logic [4:0]  sh_flags;
   logic [31:0] sh_tod, sh_tod_snap;
   logic        sh_tod_counting, sh_tod_frozen;
   logic [7:0]  sh_serial;
   logic [7:0]  sh_keys [8];
   logic [15:0] sh_bank;

   bus_item_type  pending_items[$];
   bus_reply_type expected_replies[$];
   bus_item_type  item_on_bus;
   int gap_left, burst_left, items_sent, replies_checked, mismatches, cycle_count;
   int hold_requests, hold_seen, hold_left, stall_phase;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [39:0] pack_item(bus_item_type it);
      return {5'b0, it.key_down, it.key_row, it.key_col, it.elapsed_cycles,
              it.write_data, it.reg_index};
   endfunction

   task automatic reset_shadow();
      second_unit = 0;
      sh_port_a = 8'hFF; sh_port_b = 8'hFF; sh_dir_a = 8'hFF; sh_dir_b = 8'hFF;
      sh_latch_a = TA_RESET; sh_count_a = TA_RESET;
      sh_latch_b = TB_RESET; sh_count_b = TB_RESET;
      sh_prev_count_a = 0;
      sh_cra = 8'h81; sh_crb = 0; sh_mask = 4'h1; sh_flags = 0;
      sh_tod = 0; sh_tod_snap = 0; sh_tod_counting = 1; sh_tod_frozen = 0;
      sh_serial = 0; sh_bank = 0;
      for (int i = 0; i < 8; i++) sh_keys[i] = 8'hFF;
   endtask

   function automatic logic raise_timer(int bit_no);
      if (sh_mask[bit_no]) begin
         sh_flags[bit_no] = 1;
         sh_flags[4] = 1;
         return 1;
      end
      return 0;
   endfunction

   function automatic logic count_timer_a(logic [15:0] el);
      logic fired;
      fired = 0;
      if (sh_cra & CR_FORCE) sh_count_a = sh_latch_a;
      if (sh_cra & CR_RUN) begin
         if (el > sh_count_a) begin
            sh_count_a = sh_latch_a;
            fired = raise_timer(0);
            if (sh_cra & CR_ONESHOT) sh_cra = sh_cra & ~CR_RUN;
         end else begin
            sh_count_a = sh_count_a - el;
         end
      end
      sh_cra = sh_cra & ~CR_FORCE;
      return fired;
   endfunction

   function automatic logic count_timer_b(logic [15:0] el);
      logic fired;
      fired = 0;
      if (sh_crb & CR_FORCE) sh_count_b = sh_latch_b;
      if (sh_crb & CR_RUN) begin
         if (sh_crb[6:5] < 2) begin
            if (el > sh_count_b) begin
               sh_count_b = sh_latch_b;
               fired = raise_timer(1);
               if (sh_crb & CR_ONESHOT) sh_crb = sh_crb & ~CR_RUN;
            end else begin
               sh_count_b = sh_count_b - el;
            end
         end else begin
            // Chained to timer A: it fires whenever timer A has reloaded upward.
            sh_count_b = sh_count_a;
            if (sh_count_a > sh_prev_count_a) begin
               fired = raise_timer(1);
               if (sh_crb & CR_ONESHOT) sh_crb = sh_crb & ~CR_RUN;
            end
            sh_prev_count_a = sh_count_a;
         end
      end
      sh_crb = sh_crb & ~CR_FORCE;
      return fired;
   endfunction

   task automatic advance_tod();
      logic [7:0] t, s;
      if (!sh_tod_counting) return;
      t = (sh_tod[7:0] + 8'd1) & 8'h0F;
      s = sh_tod[15:8];
      if (t == 8'h0A) begin
         t = 0;
         s = (s + 8'd1) & 8'h7F;
         if (s[3:0] == 4'hA) begin
            s = (s + 8'd6) & 8'h7F;
            if (s == 8'h60) s = 0;
         end
      end
      sh_tod[15:0] = {s, t};
   endtask

   function automatic logic [7:0] scan_keys();
      logic [7:0] inv;
      int row;
      if (sh_port_a == 8'hFF || sh_port_a == 8'h00) return 8'hFF;
      inv = ~sh_port_a;
      row = 0;
      for (int i = 0; i < 8; i++) if (inv[i]) row = i;
      return sh_keys[row];
   endfunction

   function automatic logic [7:0] shadow_reg_fetch(logic [3:0] r);
      logic [7:0] d;
      case (r)
         REG_PRA: d = second_unit ? (sh_port_a | ~(sh_dir_a & 8'h3F)) : scan_keys();
         REG_PRB: d = second_unit ? (sh_port_b | ~(sh_dir_b & 8'h3F)) : scan_keys();
         REG_DDRA: d = sh_dir_a;
         REG_DDRB: d = sh_dir_b;
         REG_TALO: d = sh_count_a[7:0];
         REG_TAHI: d = sh_count_a[15:8];
         REG_TBLO: d = sh_count_b[7:0];
         REG_TBHI: d = sh_count_b[15:8];
         REG_TOD10: begin
            d = sh_tod_frozen ? sh_tod_snap[7:0] : sh_tod[7:0];
            sh_tod_frozen = 0;
         end
         REG_TODS: d = sh_tod_frozen ? sh_tod_snap[15:8] : sh_tod[15:8];
         REG_TODM: d = sh_tod_frozen ? sh_tod_snap[23:16] : sh_tod[23:16];
         REG_TODH: begin
            sh_tod_frozen = 1;
            sh_tod_snap = sh_tod;
            d = sh_tod_snap[31:24];
         end
         REG_SDR: d = sh_serial;
         REG_ICR: begin
            d = {sh_flags[4], 2'b0, sh_flags[3], 1'b0, sh_flags[2:0]};
            sh_flags = 0;
         end
         REG_CRA: d = sh_cra & ~CR_FORCE;
         default: d = sh_crb & ~CR_FORCE;
      endcase
      return d;
   endfunction

   task automatic shadow_reg_store(logic [3:0] r, logic [7:0] v);
      logic [3:0] sel;
      case (r)
         REG_PRA: begin
            sh_port_a = v;
            if (second_unit) sh_bank = {~v[1:0], 14'b0};
         end
         REG_PRB: sh_port_b = v;
         REG_DDRA: sh_dir_a = v;
         REG_DDRB: sh_dir_b = v;
         REG_TALO: sh_latch_a[7:0] = v;
         REG_TAHI: begin
            sh_latch_a[15:8] = v;
            if (!(sh_cra & CR_RUN)) sh_count_a = sh_latch_a;
         end
         REG_TBLO: sh_latch_b[7:0] = v;
         REG_TBHI: begin
            sh_latch_b[15:8] = v;
            if (!(sh_crb & CR_RUN)) sh_count_b = sh_latch_b;
         end
         REG_TOD10: begin
            sh_tod[7:0] = v & 8'h0F;
            sh_tod_counting = 1;
         end
         REG_TODS: sh_tod[15:8] = v & 8'h7F;
         REG_TODM: sh_tod[23:16] = v & 8'h7F;
         REG_TODH: begin
            v = v & 8'h9F;
            if (v[4:0] == 5'h12 && !(sh_cra & CRA_50HZ)) v = v ^ 8'h80;
            sh_tod[31:24] = v;
            sh_tod_counting = 0;
         end
         REG_SDR: sh_serial = v;
         REG_ICR: begin
            sel = {v[4], v[2:0]};
            if (v[7]) sh_mask = sh_mask | sel;
            else sh_mask = sh_mask & ~sel;
         end
         REG_CRA: sh_cra = v | (sh_cra & CR_FORCE);
         default: sh_crb = v | (sh_crb & CR_FORCE);
      endcase
   endtask

   task automatic predict_reply(bus_item_type it);
      bus_reply_type rep;
      logic fired;
      fired = 0;
      rep.read_data = 0;
      case (it.op)
         OP_READ: rep.read_data = shadow_reg_fetch(it.reg_index);
         OP_WRITE: shadow_reg_store(it.reg_index, it.write_data);
         OP_TICK: begin
            fired = count_timer_a(it.elapsed_cycles);
            fired = count_timer_b(it.elapsed_cycles) | fired;
            advance_tod();
         end
         default: begin
            if (it.key_down) begin
               sh_port_a[it.key_col] = 0;
               sh_port_b[it.key_row] = 0;
               sh_keys[it.key_col][it.key_row] = 0;
            end else begin
               sh_port_a[it.key_col] = 1;
               sh_port_b[it.key_row] = 1;
               sh_keys[it.key_col][it.key_row] = 1;
            end
         end
      endcase
      rep.irq_pulse = fired && !second_unit;
      rep.nmi_pulse = fired && second_unit;
      rep.video_bank_base = sh_bank;
      expected_replies.push_back(rep);
   endtask

   task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
      $display("mismatch on reply %0d: %s got %h expected %h", replies_checked, field, got,
               want);
      mismatches++;
   endtask

   // Sender: bursts of transfers separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tuser <= '0;
         req_tdata <= '0;
         gap_left = 0;
         burst_left = 1;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_reply(item_on_bus);
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || pending_items.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 0;
            end else begin
               item_on_bus = pending_items.pop_front();
               req_tuser <= item_on_bus.op;
               req_tdata <= pack_item(item_on_bus);
               req_tvalid <= 1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // Receiver: windows of random stalls, clear windows, and requested long hold-offs.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               $display("reply with nothing expected: %h", rsp_tdata);
               mismatches++;
            end else begin
               bus_reply_type want;
               want = expected_replies.pop_front();
               if (rsp_tdata[7:0] !== want.read_data)
                  report_mismatch("read_data", {8'd0, rsp_tdata[7:0]},
                                  {8'd0, want.read_data});
               if (rsp_tdata[8] !== want.irq_pulse)
                  report_mismatch("irq_pulse", {15'd0, rsp_tdata[8]}, {15'd0, want.irq_pulse});
               if (rsp_tdata[9] !== want.nmi_pulse)
                  report_mismatch("nmi_pulse", {15'd0, rsp_tdata[9]}, {15'd0, want.nmi_pulse});
               if (rsp_tdata[25:10] !== want.video_bank_base)
                  report_mismatch("video_bank_base", rsp_tdata[25:10], want.video_bank_base);
               replies_checked++;
            end
         end
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = 300;
         end
         stall_phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else if (stall_phase % 128 < 48) begin
            rsp_tready <= 1;
         end else begin
            rsp_tready <= ($urandom_range(0, 2) != 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic bus_item_type make_item(logic [1:0] op, logic [3:0] r, logic [7:0] wd,
                                               logic [15:0] el);
      bus_item_type it;
      it.op = op;
      it.reg_index = r;
      it.write_data = wd;
      it.elapsed_cycles = el;
      it.key_col = 3'($urandom_range(0, 7));
      it.key_row = 3'($urandom_range(0, 7));
      it.key_down = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic bus_item_type random_item();
      bus_item_type it;
      int pick;
      pick = $urandom_range(0, 99);
      it = make_item(OP_READ, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                     16'($urandom_range(0, 65535)));
      if (pick < 30) begin
         it.op = OP_READ;
      end else if (pick < 60) begin
         it.op = OP_WRITE;
         // Keep timer latches small so that underflows happen often.
         if (it.reg_index == REG_TAHI || it.reg_index == REG_TBHI)
            it.write_data = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
         if (it.reg_index == REG_ICR && $urandom_range(0, 1)) it.write_data[7] = 1;
      end else if (pick < 90) begin
         it.op = OP_TICK;
         if ($urandom_range(0, 9) != 0) it.elapsed_cycles = 16'($urandom_range(0, 300));
      end else begin
         it.op = OP_KEY;
      end
      return it;
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_replies.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_unit_select(logic v);
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock);
      while (!csr_ready);
      second_unit = v;
      csr_valid <= 0;
   endtask

   task automatic queue_random(int n);
      for (int i = 0; i < n; i++) pending_items.push_back(random_item());
   endtask

   initial begin
      reset <= 1;
      csr_valid <= 0;
      csr_data <= 0;
      req_tvalid <= 0;
      req_tuser <= '0;
      req_tdata <= '0;
      rsp_tready <= 0;
      items_sent = 0;
      replies_checked = 0;
      mismatches = 0;
      cycle_count = 0;
      hold_requests = 0;
      hold_seen = 0;
      stall_phase = 0;
      reset_shadow();
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_unit_select(0);
      // Directed part: reset values, field extremes and the documented corner cases.
      pending_items.push_back(make_item(OP_READ, REG_TALO, 8'h00, 16'h0000));
      pending_items.push_back(make_item(OP_READ, REG_CRA, 8'hFF, 16'hFFFF));
      pending_items.push_back(make_item(OP_TICK, REG_CRB, 8'h00, 16'hFFFF));
      pending_items.push_back(make_item(OP_TICK, REG_PRA, 8'hFF, 16'h0000));
      pending_items.push_back(make_item(OP_READ, REG_ICR, 8'h00, 16'h0000));
      pending_items.push_back(make_item(OP_WRITE, REG_ICR, 8'hFF, 16'h0000));
      pending_items.push_back(make_item(OP_WRITE, REG_CRA, 8'h19, 16'h0000));
      pending_items.push_back(make_item(OP_TICK, REG_PRA, 8'h00, 16'h5000));
      pending_items.push_back(make_item(OP_WRITE, REG_CRA, 8'h00, 16'h0000));
      pending_items.push_back(make_item(OP_WRITE, REG_TAHI, 8'h00, 16'h0000));
      pending_items.push_back(make_item(OP_WRITE, REG_TBHI, 8'h00, 16'h0000));
      pending_items.push_back(make_item(OP_WRITE, REG_CRA, 8'h01, 16'h0000));
      pending_items.push_back(make_item(OP_WRITE, REG_CRB, 8'h61, 16'h0000));
      pending_items.push_back(make_item(OP_TICK, REG_PRA, 8'h00, 16'h0030));
      pending_items.push_back(make_item(OP_TICK, REG_PRA, 8'h00, 16'h0030));
      pending_items.push_back(make_item(OP_WRITE, REG_TODH, 8'h92, 16'h0000));
      pending_items.push_back(make_item(OP_READ, REG_TODH, 8'h00, 16'h0000));
      pending_items.push_back(make_item(OP_WRITE, REG_TOD10, 8'h09, 16'h0000));
      pending_items.push_back(make_item(OP_TICK, REG_PRA, 8'h00, 16'h0001));
      pending_items.push_back(make_item(OP_READ, REG_TODS, 8'h00, 16'h0000));
      pending_items.push_back(make_item(OP_READ, REG_TOD10, 8'h00, 16'h0000));
      pending_items.push_back(make_item(OP_WRITE, REG_PRA, 8'hFE, 16'h0000));
      begin
         bus_item_type k;
         k = make_item(OP_KEY, REG_PRA, 8'h00, 16'h0000);
         k.key_col = 7; k.key_row = 7; k.key_down = 1;
         pending_items.push_back(k);
         k.key_col = 0; k.key_row = 0; k.key_down = 0;
         pending_items.push_back(k);
      end
      pending_items.push_back(make_item(OP_READ, REG_PRA, 8'h00, 16'h0000));
      queue_random(110);
      wait_idle();

      // The second unit with a long receiver hold-off so the block backs up.
      write_unit_select(1);
      hold_requests++;
      queue_random(140);
      // The test pauses here until everything has drained.
      wait_idle();
      queue_random(20);
      wait_idle();

      write_unit_select(0);
      queue_random(110);
      wait_idle();
      repeat (10) @(posedge clock);

      $display("Sent %0d bus items across both unit settings; %0d replies checked.",
               items_sent, replies_checked);
      $display("Covered timers, chaining, interrupts, time of day, keys and stalls.");
      if (mismatches == 0 && expected_replies.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> files.f
src/cia_pkg.sv
src/cia_timer.sv
src/complex_interface_adapter_core.sv
src/cia_checker.sv
bench/tb_top.sv
